>>> design/rob_pkg.sv
// Shared types and constants for the RGBA over-blend pipeline.
package rob_pkg;

    // Color lanes carried through the divider: red, green, blue.
    localparam int NumCh = 3;
    localparam logic [7:0] ALPHA_MAX = 8'd255;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pix_t;

    // Products stage: raw multiplier outputs plus pass-through data.
    typedef struct packed {
        logic [7:0]            oa;
        logic [15:0]           t;
        logic [NumCh-1:0][15:0] oc_oa;
        logic                  bypass;
        logic                  den_zero;
        pix_t                  base;
        logic                  frame_end;
    } prod_t;

    // Divider stages: denominator, partial remainders and quotients.
    typedef struct packed {
        logic [15:0]            den;
        logic [NumCh-1:0][23:0] rem;
        logic [NumCh-1:0][7:0]  quo;
        logic                   bypass;
        logic                   den_zero;
        pix_t                   base;
        logic                   frame_end;
    } div_item_t;

    // Color bytes of a pixel as lanes, red in lane 0.
    function automatic logic [NumCh-1:0][7:0] pix_colors(pix_t p);
        return {p.blue, p.green, p.red};
    endfunction

endpackage

>>> design/rgba_over_blend_core.sv
// Top level of the RGBA over-blend pixel pipeline.
// Blends a non-premultiplied overlay color onto a base RGBA pixel with the
// exact-integer over operator; an all-zero overlay word passes the base pixel
// through. One pixel request is taken per clock while the output side does not
// stall, and its result passes two multiply stages (products, then denominator
// and numerators), four restoring-divider stages retiring two quotient bits each,
// and the output register. Each stage holds its own valid bit, so bubbles collapse
// under backpressure and s_tready follows m_tready through the stage ready chain
// in the same cycle.
module rgba_over_blend_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] base_red, [15:8] base_green, [23:16] base_blue, [31:24] base_alpha,
    // [63:32] overlay_word
    input  logic [63:0] s_tdata,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_red, [15:8] out_green, [23:16] out_blue, [31:24] out_alpha
    output logic [31:0] m_tdata,
    output logic        m_tlast
);
    import rob_pkg::*;

    localparam int NumDiv = 4;

    pix_t      s_base;
    pix_t      m_pix;
    div_item_t div_item [NumDiv+1];
    logic      div_valid [NumDiv+1];
    logic      div_ready [NumDiv+1];

    assign s_base.red   = s_tdata[7:0];
    assign s_base.green = s_tdata[15:8];
    assign s_base.blue  = s_tdata[23:16];
    assign s_base.alpha = s_tdata[31:24];

    // Products and numerators
    rob_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_base    (s_base),
        .in_overlay (s_tdata[63:32]),
        .in_last    (s_tlast),
        .out_valid  (div_valid[0]),
        .out_ready  (div_ready[0]),
        .out_item   (div_item[0])
    );

    // Divider pipeline, quotient bits 7:6 first
    for (genvar i = 0; i < NumDiv; i++) begin : g_div
        rob_div_stage #(
            .HI_BIT (7 - 2 * i)
        ) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (div_valid[i]),
            .in_ready  (div_ready[i]),
            .in_item   (div_item[i]),
            .out_valid (div_valid[i+1]),
            .out_ready (div_ready[i+1]),
            .out_item  (div_item[i+1])
        );
    end

    // Final select and output register
    rob_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_valid[NumDiv]),
        .in_ready  (div_ready[NumDiv]),
        .in_item   (div_item[NumDiv]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pix   (m_pix),
        .out_last  (m_tlast)
    );

    assign m_tdata = {m_pix.alpha, m_pix.blue, m_pix.green, m_pix.red};

endmodule

>>> design/rob_front.sv
// Front end: alpha/color products, then denominator and numerators.
module rob_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  rob_pkg::pix_t       in_base,
    input  logic [31:0]         in_overlay,
    input  logic                in_last,
    output logic                out_valid,
    input  logic                out_ready,
    output rob_pkg::div_item_t  out_item
);
    import rob_pkg::*;

    logic [NumCh-1:0][7:0] ov_col;
    logic [NumCh-1:0][7:0] base_col;
    logic [7:0]            oa;
    prod_t                 prod_reg, prod_next;
    logic                  prod_valid_reg;
    logic                  prod_ready;
    div_item_t             item_reg, item_next;
    logic                  item_valid_reg;
    logic [15:0]           oa_255;

    assign ov_col = in_overlay[23:0];
    assign oa     = in_overlay[31:24];

    // Stage A: 8x8 products
    always_comb begin
        prod_next.oa = oa;
        prod_next.t  = 16'(in_base.alpha) * 16'(ALPHA_MAX - oa);
        for (int c = 0; c < NumCh; c++) begin
            prod_next.oc_oa[c] = 16'(ov_col[c]) * 16'(oa);
        end
        prod_next.bypass    = (in_overlay == 32'h0);
        prod_next.den_zero  = (oa == 8'h00) && (in_base.alpha == 8'h00);
        prod_next.base      = in_base;
        prod_next.frame_end = in_last;
    end

    assign in_ready   = !prod_valid_reg || prod_ready;
    assign prod_ready = !item_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else if (in_ready) begin
            prod_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            prod_reg <= prod_next;
        end
    end

    // Stage B: D = oa*255 + t, num = oc*oa*255 + bc*t
    assign oa_255   = {prod_reg.oa, 8'h00} - 16'(prod_reg.oa);
    assign base_col = pix_colors(prod_reg.base);

    always_comb begin
        item_next.den = oa_255 + prod_reg.t;
        for (int c = 0; c < NumCh; c++) begin
            item_next.rem[c] = ({prod_reg.oc_oa[c], 8'h00} - 24'(prod_reg.oc_oa[c]))
                             + 24'(base_col[c]) * 24'(prod_reg.t);
        end
        item_next.quo       = '0;
        item_next.bypass    = prod_reg.bypass;
        item_next.den_zero  = prod_reg.den_zero;
        item_next.base      = prod_reg.base;
        item_next.frame_end = prod_reg.frame_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (prod_ready) begin
            item_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_ready && prod_valid_reg) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = item_valid_reg;
    assign out_item  = item_reg;

endmodule

>>> design/rob_div_stage.sv
// One restoring-divider stage: two quotient bits for each color lane.
module rob_div_stage #(
    parameter int HI_BIT = 7
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  rob_pkg::div_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output rob_pkg::div_item_t  out_item
);
    import rob_pkg::*;

    logic [23:0]            den_hi, den_lo;
    logic [NumCh-1:0][23:0] rem_mid;
    div_item_t              item_reg, item_next;
    logic                   valid_reg;

    assign den_hi = {8'h00, in_item.den} << HI_BIT;
    assign den_lo = {8'h00, in_item.den} << (HI_BIT - 1);

    // Two compare/subtract steps per lane
    always_comb begin
        item_next = in_item;
        for (int c = 0; c < NumCh; c++) begin
            if (in_item.rem[c] >= den_hi) begin
                rem_mid[c]                 = in_item.rem[c] - den_hi;
                item_next.quo[c][HI_BIT]   = 1'b1;
            end else begin
                rem_mid[c]                 = in_item.rem[c];
            end
            if (rem_mid[c] >= den_lo) begin
                item_next.rem[c]             = rem_mid[c] - den_lo;
                item_next.quo[c][HI_BIT - 1] = 1'b1;
            end else begin
                item_next.rem[c]             = rem_mid[c];
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

>>> design/rob_out.sv
// Output stage: alpha = D/255, bypass and zero-alpha select, output register.
module rob_out (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  rob_pkg::div_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output rob_pkg::pix_t       out_pix,
    output logic                out_last
);
    import rob_pkg::*;

    logic [16:0] alpha_sum;
    pix_t        pix_reg, pix_next;
    logic        last_reg;
    logic        valid_reg;

    // floor(D/255) for D up to 65534: (D + 1 + (D >> 8)) >> 8
    assign alpha_sum = 17'(in_item.den) + 17'd1 + 17'(in_item.den[15:8]);

    always_comb begin
        if (in_item.bypass) begin
            pix_next = in_item.base;
        end else if (in_item.den_zero) begin
            pix_next = '0;
        end else begin
            // numerator never exceeds 255*D, so the quotient fits in 8 bits
            pix_next.red   = in_item.quo[0];
            pix_next.green = in_item.quo[1];
            pix_next.blue  = in_item.quo[2];
            pix_next.alpha = alpha_sum[15:8];
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            pix_reg  <= pix_next;
            last_reg <= in_item.frame_end;
        end
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;
    assign out_last  = last_reg;

endmodule

>>> design/rob_checker.sv
// Port-level checks for the over-blend core, bound to the top level.
module rob_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result request valid right after reset");

    // a stalled result request holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result request changed");

    // an open or empty output stage lets a new request in
    a_ready_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tready || !m_tvalid) |-> s_tready)
        else $error("input blocked while output can move");

endmodule

bind rgba_over_blend_core rob_checker u_rob_checker (.*);

>>> test/tb.sv
// Self-checking testbench for the RGBA over-blend pixel pipeline.
`timescale 1ns / 100ps

module tb;
    import rob_pkg::*;

    localparam int RandomPixels = 1600;
    localparam int CycleLimit   = 200000;
    localparam int DrainCycles  = 16;

    // One blended pixel as it leaves the block
    typedef struct packed {
        pix_t px;
        logic last;
    } blended_t;

    // Hand-written expectation for a directed row, if there is one
    typedef struct packed {
        logic fixed;
        pix_t px;
    } known_t;

    // Directed stimulus row: base, overlay, frame end, typed result
    typedef struct packed {
        pix_t        base;
        logic [31:0] ow;
        logic        last;
        logic        fixed;
        pix_t        want;
    } stim_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [7:0] base_red, [15:8] base_green, [23:16] base_blue, [31:24] base_alpha,
    // [63:32] overlay_word
    logic [63:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [7:0] out_red, [15:8] out_green, [23:16] out_blue, [31:24] out_alpha
    logic [31:0] m_tdata;
    logic        m_tlast;

    blended_t blended_q[$];
    known_t   known_q[$];
    int       fails      = 0;
    int       cycles     = 0;
    int       burst_left = 0;
    int       stall_left = 0;
    int       stall_mode = 0;

    stim_row_t directed_rows [16] = '{
        // no overlay: base passes through
        '{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1, 32'hFFFF_FFFF},
        '{32'h1234_5678, 32'h0000_0000, 1'b1, 1'b1, 32'h1234_5678},
        // opaque overlay replaces the pixel
        '{32'h9ABC_DEF0, 32'hFF80_4020, 1'b0, 1'b1, 32'hFF80_4020},
        '{32'hFFFF_FFFF, 32'hFF00_0000, 1'b0, 1'b1, 32'hFF00_0000},
        '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF},
        '{32'h55AA_55AA, 32'hFFFF_FFFE, 1'b1, 1'b1, 32'hFFFF_FFFE},
        // both alphas zero: everything zero
        '{32'h00AB_CDEF, 32'h00FF_FFFF, 1'b0, 1'b1, 32'h0000_0000},
        '{32'h00FF_FFFF, 32'h0000_0001, 1'b1, 1'b1, 32'h0000_0000},
        // one alpha zero: the pixel with nonzero alpha comes through
        '{32'hFFC0_8040, 32'h0011_2233, 1'b0, 1'b1, 32'hFFC0_8040},
        '{32'h01FF_FFFF, 32'h00FF_FFFF, 1'b0, 1'b1, 32'h01FF_FFFF},
        '{32'h00FF_FFFF, 32'h01FF_8001, 1'b0, 1'b1, 32'h01FF_8001},
        // partial alphas, left to the predictor
        '{32'h8000_FF00, 32'h80FF_00FF, 1'b0, 1'b0, 32'h0000_0000},
        '{32'hFEFE_FEFE, 32'h0101_0101, 1'b0, 1'b0, 32'h0000_0000},
        '{32'hFFFF_FFFF, 32'hFE00_0000, 1'b0, 1'b0, 32'h0000_0000},
        '{32'h7F7F_7F7F, 32'h8080_8080, 1'b1, 1'b0, 32'h0000_0000}
    };

    rgba_over_blend_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #6 aclk = ~aclk;

    // One color lane of the over operator; zero denominator gives zero
    function automatic logic [7:0] over_lane(int unsigned oc, int unsigned bc,
                                             int unsigned oa, int unsigned ba,
                                             int unsigned den);
        int unsigned num;
        int unsigned q;
        if (den == 0)
            return 8'd0;
        num = oc * oa * 255 + bc * ba * (255 - oa);
        q = num / den;
        return (q > 255) ? ALPHA_MAX : q[7:0];
    endfunction

    // Blend an overlay word onto a base pixel
    function automatic pix_t blend_over(pix_t base, logic [31:0] ow);
        pix_t        res;
        int unsigned oa;
        int unsigned ba;
        int unsigned den;
        if (ow == '0)
            return base;
        oa  = 32'(ow[31:24]);
        ba  = 32'(base.alpha);
        den = oa * 255 + ba * (255 - oa);
        res.red   = over_lane(32'(ow[7:0]),   32'(base.red),   oa, ba, den);
        res.green = over_lane(32'(ow[15:8]),  32'(base.green), oa, ba, den);
        res.blue  = over_lane(32'(ow[23:16]), 32'(base.blue),  oa, ba, den);
        res.alpha = (den / 255 > 255) ? ALPHA_MAX : 8'(den / 255);
        return res;
    endfunction

    // Alpha values at and next to the ends of the range
    function automatic logic [7:0] alpha_extreme();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("[rgba_over_blend_core] ERROR");
            $finish;
        end
    end

    // Output stall pattern: modes held for random stretches
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 4);
            stall_left = $urandom_range(8, 120);
        end
        stall_left--;
        case (stall_mode)
            0, 1:    m_tready <= 1'b1;
            2:       m_tready <= ($urandom_range(0, 1) == 1);
            3:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ~m_tready;
        endcase
    end

    // Predict on each accepted request, compare on each accepted result
    always @(posedge aclk) begin
        blended_t want;
        blended_t got;
        known_t   k;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                k = (known_q.size() != 0) ? known_q.pop_front() : '0;
                want.px   = k.fixed ? k.px : blend_over(pix_t'(s_tdata[31:0]),
                                                        s_tdata[63:32]);
                want.last = s_tlast;
                blended_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.px   = m_tdata;
                got.last = m_tlast;
                if (blended_q.size() == 0) begin
                    $error("unexpected result %h last %b", m_tdata, m_tlast);
                    fails++;
                end else begin
                    want = blended_q.pop_front();
                    check_field("out_red",   32'(want.px.red),   32'(got.px.red));
                    check_field("out_green", 32'(want.px.green), 32'(got.px.green));
                    check_field("out_blue",  32'(want.px.blue),  32'(got.px.blue));
                    check_field("out_alpha", 32'(want.px.alpha), 32'(got.px.alpha));
                    check_field("frame_end_out", 32'(want.last), 32'(got.last));
                end
            end
        end
    end

    // Present one pixel request, bursts separated by random gaps
    task automatic send_pixel(pix_t base, logic [31:0] ow, logic last,
                              logic fixed, pix_t want);
        int     gap;
        known_t k;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 4) ? 0 :
                  ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) :
                  $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) :
                         $urandom_range(1, 24);
        end
        burst_left--;
        k.fixed = fixed;
        k.px    = want;
        known_q.push_back(k);
        s_tvalid <= 1'b1;
        s_tdata  <= {ow, base};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stimulus
    initial begin
        pix_t        base;
        logic [31:0] ow;
        int          sel;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows
        foreach (directed_rows[i])
            send_pixel(directed_rows[i].base, directed_rows[i].ow, directed_rows[i].last,
                       directed_rows[i].fixed, directed_rows[i].want);

        // random pixels, weighted toward the special cases
        for (int n = 0; n < RandomPixels; n++) begin
            base = pix_t'($urandom);
            ow   = $urandom;
            sel  = $urandom_range(0, 99);
            if (sel < 10) begin
                ow = '0;
            end else if (sel < 25) begin
                ow[31:24]  = alpha_extreme();
                base.alpha = alpha_extreme();
            end else if (sel < 33) begin
                ow[31:24]  = 8'd0;
                base.alpha = 8'd0;
                if (ow == '0)
                    ow[0] = 1'b1;
            end
            send_pixel(base, ow, ($urandom_range(0, 15) == 0), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        // drain, then leave room for stray results
        while (known_q.size() != 0 || blended_q.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        if (fails == 0)
            $display("[rgba_over_blend_core] OK");
        else
            $display("[rgba_over_blend_core] ERROR");
        $finish;
    end

endmodule
